>>> hw/rtl/analog_samples_to_field_line_time_macros.svh
// assertion macros for the delay to field / line / time converter
`ifndef ANALOG_SAMPLES_TO_FIELD_LINE_TIME_MACROS_SVH
`define ANALOG_SAMPLES_TO_FIELD_LINE_TIME_MACROS_SVH
`ifndef SYNTHESIS
`define ASFL_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("asfl check failed");
`define ASFL_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("asfl check failed");
`else
`define ASFL_ASSERT_IMP(label, clk, rst_n, pre, post)
`define ASFL_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

>>> hw/rtl/asfl_pkg.sv
// widths and timing constants for the delay to field / line / time converter
`default_nettype none
package asfl_pkg;
    localparam int unsigned CNT_W   = 31;
    localparam int unsigned FIELD_W = 3;
    localparam int unsigned LINE_W  = 9;
    localparam int unsigned TIME_W  = 20;
    localparam int unsigned REM_W   = 29;
    localparam int unsigned LNUM_W  = 10;
    localparam int unsigned SUB_W   = 19;

    // sequence timing in 1/256 sample units
    localparam logic [CNT_W-1:0] FRAME_625 = 31'd276480000;
    localparam logic [CNT_W-1:0] FRAME_525 = 31'd230630400;
    localparam logic [CNT_W-1:0] HALF_625  = 31'd552960000;
    localparam logic [CNT_W-1:0] HALF_525  = 31'd230630400;
    localparam logic [CNT_W-1:0] SEQ_625   = 31'd1105920000;
    localparam logic [CNT_W-1:0] SEQ_525   = 31'd461260800;
    localparam logic [SUB_W-1:0] LLEN_625  = 19'd442368;
    localparam logic [SUB_W-1:0] LLEN_525  = 19'd439296;

    // line length = 27 << 14 or 429 << 10
    localparam logic [4:0] LMUL_625 = 5'd27;
    localparam logic [8:0] LMUL_525 = 9'd429;

    // reciprocals: x / 27 for x < 2^15, x / 429 for x < 2^18
    localparam logic [15:0] RCP27_L  = 16'd38837;
    localparam logic [18:0] RCP429_L = 19'd312862;

    // reciprocal of 27 for x < 2^25, shift 30
    localparam logic [25:0] RCP27_T = 26'd39768216;

    localparam logic [13:0] NS_SCALE = 14'd10000;
    localparam logic [11:0] NS_ROUND = 12'd3456;

    localparam logic [LNUM_W-1:0] FIRST_625 = 10'd313;
    localparam logic [LNUM_W-1:0] FIRST_525 = 10'd263;
    localparam logic [LNUM_W-1:0] LAST_625  = 10'd624;
    localparam logic [LNUM_W-1:0] LAST_525  = 10'd524;
    localparam logic [FIELD_W-1:0] TOP_625  = 3'd7;
    localparam logic [FIELD_W-1:0] TOP_525  = 3'd3;
    localparam logic [FIELD_W-1:0] MID_625  = 3'd4;
    localparam logic [FIELD_W-1:0] MID_525  = 3'd2;
endpackage
`default_nettype wire

>>> hw/rtl/asfl_in_if.sv
// delay count channel
`default_nettype none
interface asfl_in_if;
    import asfl_pkg::*;
    logic               valid;
    logic               ready;
    logic [CNT_W-1:0]   delay_count;
    modport source (output valid, output delay_count, input ready);
    modport sink (input valid, input delay_count, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/asfl_out_if.sv
// field / line / time result channel
`default_nettype none
interface asfl_out_if;
    import asfl_pkg::*;
    logic               valid;
    logic               ready;
    logic               negative;
    logic [FIELD_W-1:0] field_number;
    logic [LINE_W-1:0]  line_number;
    logic [TIME_W-1:0]  time_tenths_ns;
    logic               out_of_range;
    modport source (output valid, output negative, output field_number, output line_number,
                    output time_tenths_ns, output out_of_range, input ready);
    modport sink (input valid, input negative, input field_number, input line_number,
                  input time_tenths_ns, input out_of_range, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/analog_samples_to_field_line_time.sv
// Genlock delay converter: sub-sample count to sign, field, line and residual time.
// Usage:
//   delay  - valid/ready channel carrying delay_count, a count of 1/256 samples
//            across the colour-frame sequence; a word is taken when valid and ready are high.
//   result - valid/ready channel giving negative, field_number, line_number,
//            time_tenths_ns and out_of_range, one word for each delay word.
//   cfg_wr_en / cfg_wr_data - mode register write: 0 selects 625-line, 1 selects
//            525-line timing. Write only while no word is in flight.
// A delay word passes through the eight-stage pipeline (fold, frame compare, frame
// remainder, line reciprocal multiply, residual, mirror, time scale, reciprocal
// divide by 27); one word per cycle is sustained while result.ready stays high.
// Each stage holds a valid bit.
// Reset empties the pipeline and selects 625-line timing.
// When result.ready is low, the last stage holds its word; earlier stages keep
// filling bubbles and delay.ready drops only once every stage is full.
`default_nettype none
`include "analog_samples_to_field_line_time_macros.svh"
module analog_samples_to_field_line_time (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_wr_en,
    input  wire logic   cfg_wr_data,
    asfl_in_if.sink     delay,
    asfl_out_if.source  result
);
    import asfl_pkg::*;

    localparam int unsigned NSTAGE = 8;

    logic              sys525_reg;
    logic [NSTAGE:1]   v_reg;
    logic [NSTAGE:1]   v_src;
    logic [NSTAGE:1]   rdy;

    // stage 1: range check and fold
    logic              s1_is_reg, s1_oor_reg, s1_neg_reg;
    logic [CNT_W-1:0]  s1_c_reg;
    logic              s1_oor_next, s1_neg_next;
    logic [CNT_W-1:0]  s1_c_next, half_sel, seq_sel;
    // stage 2: frame
    logic              s2_is_reg, s2_oor_reg, s2_neg_reg;
    logic [1:0]        s2_frame_reg;
    logic [CNT_W-1:0]  s2_c_reg;
    logic [1:0]        s2_frame_next;
    logic              ge1, ge2, ge3;
    // stage 3: remainder within frame
    logic              s3_is_reg, s3_oor_reg, s3_neg_reg;
    logic [1:0]        s3_frame_reg;
    logic [REM_W-1:0]  s3_rem_reg;
    logic [CNT_W-1:0]  frame_off;
    logic [CNT_W-1:0]  s3_diff;
    // stage 4: line
    logic              s4_is_reg, s4_oor_reg, s4_neg_reg;
    logic [1:0]        s4_frame_reg;
    logic [REM_W-1:0]  s4_rem_reg;
    logic [LNUM_W-1:0] s4_line_reg;
    logic [30:0]       p625;
    logic [36:0]       p525;
    logic [LNUM_W-1:0] s4_line_next;
    // stage 5: residual sub-samples
    logic              s5_is_reg, s5_oor_reg, s5_neg_reg;
    logic [1:0]        s5_frame_reg;
    logic [LNUM_W-1:0] s5_line_reg;
    logic [SUB_W-1:0]  s5_sub_reg;
    logic [REM_W-1:0]  lprod;
    logic [REM_W-1:0]  s5_diff;
    // stage 6: field and mirror
    logic              s6_oor_reg, s6_neg_reg;
    logic [FIELD_W-1:0] s6_field_reg;
    logic [LINE_W-1:0] s6_line_reg;
    logic [SUB_W-1:0]  s6_sub_reg;
    logic              s6_neg_next;
    logic [FIELD_W-1:0] s6_field_next, field2x;
    logic [LNUM_W-1:0] s6_line_next, first_sel, last_sel;
    logic [SUB_W-1:0]  s6_sub_next, llen_sel;
    logic [FIELD_W-1:0] top_sel, mid_sel;
    logic              in_second;
    // stage 7: scaled time before divide by 27
    logic              s7_oor_reg, s7_neg_reg;
    logic [FIELD_W-1:0] s7_field_reg;
    logic [LINE_W-1:0] s7_line_reg;
    logic [24:0]       s7_a_reg;
    logic [32:0]       scaled;
    // stage 8: output word
    logic              s8_oor_reg, s8_neg_reg;
    logic [FIELD_W-1:0] s8_field_reg;
    logic [LINE_W-1:0] s8_line_reg;
    logic [TIME_W-1:0] s8_time_reg;
    logic [50:0]       tprod;

    // ready chain: a stage loads when empty or when its word moves on
    always_comb
    begin
        rdy[NSTAGE] = !v_reg[NSTAGE] || result.ready;
        for (int k = NSTAGE - 1; k >= 1; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k + 1];
        end
    end

    assign v_src       = {v_reg[NSTAGE-1:1], delay.valid};
    assign delay.ready = rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            sys525_reg <= 1'b0;
        end
        else
        begin
            for (int k = 1; k <= NSTAGE; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_src[k];
                end
            end
            if (cfg_wr_en)
            begin
                sys525_reg <= cfg_wr_data;
            end
        end
    end

    // stage 1
    always_comb
    begin
        half_sel    = sys525_reg ? HALF_525 : HALF_625;
        seq_sel     = sys525_reg ? SEQ_525 : SEQ_625;
        s1_oor_next = delay.delay_count >= seq_sel;
        s1_neg_next = !s1_oor_next && (delay.delay_count >= half_sel);
        s1_c_next   = s1_neg_next ? delay.delay_count - 31'd1 : delay.delay_count;
    end

    // stage 2
    always_comb
    begin
        ge1 = s1_c_reg >= (s1_is_reg ? FRAME_525 : FRAME_625);
        ge2 = s1_c_reg >= HALF_625;
        ge3 = s1_c_reg >= 31'(3 * 276480000);
        s2_frame_next = s1_is_reg ? {1'b0, ge1} : 2'(ge1) + 2'(ge2) + 2'(ge3);
    end

    // stage 3
    always_comb
    begin
        case (s2_frame_reg)
            2'd0:    frame_off = '0;
            2'd1:    frame_off = s2_is_reg ? FRAME_525 : FRAME_625;
            2'd2:    frame_off = HALF_625;
            default: frame_off = 31'(3 * 276480000);
        endcase
        s3_diff = s2_c_reg - frame_off;
    end

    // stage 4: line = rem / line length by reciprocal
    always_comb
    begin
        p625 = 31'(s3_rem_reg[28:14]) * 31'(RCP27_L);
        p525 = 37'(s3_rem_reg[27:10]) * 37'(RCP429_L);
        s4_line_next = s3_is_reg ? p525[36:27] : p625[29:20];
    end

    // stage 5
    always_comb
    begin
        if (s4_is_reg)
        begin
            lprod = REM_W'({19'(s4_line_reg) * 19'(LMUL_525), 10'd0});
        end
        else
        begin
            lprod = REM_W'({15'(s4_line_reg) * 15'(LMUL_625), 14'd0});
        end
        s5_diff = s4_rem_reg - lprod;
    end

    // stage 6: second field and negative mirror
    always_comb
    begin
        first_sel = s5_is_reg ? FIRST_525 : FIRST_625;
        last_sel  = s5_is_reg ? LAST_525 : LAST_625;
        llen_sel  = s5_is_reg ? LLEN_525 : LLEN_625;
        top_sel   = s5_is_reg ? TOP_525 : TOP_625;
        mid_sel   = s5_is_reg ? MID_525 : MID_625;
        in_second = s5_line_reg >= first_sel;
        field2x   = {s5_frame_reg, in_second};
        if (s5_neg_reg)
        begin
            s6_line_next  = in_second ? last_sel - s5_line_reg
                                      : first_sel - 10'd1 - s5_line_reg;
            s6_sub_next   = llen_sel - 19'd1 - s5_sub_reg;
            s6_field_next = top_sel - field2x;
            s6_neg_next   = s6_field_next != mid_sel;
        end
        else
        begin
            s6_line_next  = in_second ? s5_line_reg - first_sel : s5_line_reg;
            s6_sub_next   = s5_sub_reg;
            s6_field_next = field2x;
            s6_neg_next   = 1'b0;
        end
    end

    // stage 7: (sub * 10000 + 3456) / 256
    assign scaled = 33'(s6_sub_reg) * 33'(NS_SCALE) + 33'(NS_ROUND);

    // stage 8: divide by 27
    assign tprod = 51'(s7_a_reg) * 51'(RCP27_T);

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s1_is_reg  <= sys525_reg;
            s1_oor_reg <= s1_oor_next;
            s1_neg_reg <= s1_neg_next;
            s1_c_reg   <= s1_c_next;
        end
        if (rdy[2])
        begin
            s2_is_reg    <= s1_is_reg;
            s2_oor_reg   <= s1_oor_reg;
            s2_neg_reg   <= s1_neg_reg;
            s2_frame_reg <= s2_frame_next;
            s2_c_reg     <= s1_c_reg;
        end
        if (rdy[3])
        begin
            s3_is_reg    <= s2_is_reg;
            s3_oor_reg   <= s2_oor_reg;
            s3_neg_reg   <= s2_neg_reg;
            s3_frame_reg <= s2_frame_reg;
            s3_rem_reg   <= s3_diff[REM_W-1:0];
        end
        if (rdy[4])
        begin
            s4_is_reg    <= s3_is_reg;
            s4_oor_reg   <= s3_oor_reg;
            s4_neg_reg   <= s3_neg_reg;
            s4_frame_reg <= s3_frame_reg;
            s4_rem_reg   <= s3_rem_reg;
            s4_line_reg  <= s4_line_next;
        end
        if (rdy[5])
        begin
            s5_is_reg    <= s4_is_reg;
            s5_oor_reg   <= s4_oor_reg;
            s5_neg_reg   <= s4_neg_reg;
            s5_frame_reg <= s4_frame_reg;
            s5_line_reg  <= s4_line_reg;
            s5_sub_reg   <= s5_diff[SUB_W-1:0];
        end
        if (rdy[6])
        begin
            s6_oor_reg   <= s5_oor_reg;
            s6_neg_reg   <= s6_neg_next;
            s6_field_reg <= s6_field_next;
            s6_line_reg  <= s6_line_next[LINE_W-1:0];
            s6_sub_reg   <= s6_sub_next;
        end
        if (rdy[7])
        begin
            s7_oor_reg   <= s6_oor_reg;
            s7_neg_reg   <= s6_neg_reg;
            s7_field_reg <= s6_field_reg;
            s7_line_reg  <= s6_line_reg;
            s7_a_reg     <= scaled[32:8];
        end
        if (rdy[8])
        begin
            // out of range words carry zeros
            s8_oor_reg   <= s7_oor_reg;
            s8_neg_reg   <= s7_neg_reg && !s7_oor_reg;
            s8_field_reg <= s7_oor_reg ? '0 : s7_field_reg;
            s8_line_reg  <= s7_oor_reg ? '0 : s7_line_reg;
            s8_time_reg  <= s7_oor_reg ? '0 : tprod[49:30];
        end
    end

    assign result.valid          = v_reg[NSTAGE];
    assign result.negative       = s8_neg_reg;
    assign result.field_number   = s8_field_reg;
    assign result.line_number    = s8_line_reg;
    assign result.time_tenths_ns = s8_time_reg;
    assign result.out_of_range   = s8_oor_reg;

    `ASFL_ASSERT_IMP(a_oor_zero, clk, rst_n, result.valid && result.out_of_range, !result.negative && (result.field_number == 3'd0) && (result.line_number == 9'd0) && (result.time_tenths_ns == 20'd0))
    `ASFL_ASSERT_IMP(a_stall_cause, clk, rst_n, !delay.ready, result.valid && !result.ready && (v_reg == '1))
    `ASFL_ASSERT_NXT(a_enter, clk, rst_n, delay.valid && delay.ready, v_reg[1])
    `ASFL_ASSERT_IMP(a_time_bound, clk, rst_n, result.valid, result.time_tenths_ns <= 20'd640000)

endmodule
`default_nettype wire

>>> tb/sv/analog_samples_to_field_line_time_test.sv
// self-checking testbench for the genlock delay to field / line / time converter
`timescale 1ns / 1ps
module analog_samples_to_field_line_time_test;
    import asfl_pkg::*;

    localparam logic MODE_625 = 1'b0;
    localparam logic MODE_525 = 1'b1;

    localparam longint unsigned LINE_LEN_625  = 64'd1728 * 256;
    localparam longint unsigned LINE_LEN_525  = 64'd1716 * 256;
    localparam longint unsigned FRAME_LEN_625 = 64'd625 * 1728 * 256;
    localparam longint unsigned FRAME_LEN_525 = 64'd525 * 1716 * 256;
    localparam longint unsigned HALF_LEN_625  = 64'd2 * 625 * 1728 * 256;
    localparam longint unsigned HALF_LEN_525  = FRAME_LEN_525;
    localparam longint unsigned SUBS_PER_US   = 64'd6912;

    localparam int RESET_CYCLES       = 11;
    localparam int SETTLE_CYCLES      = 16;
    localparam int HOLD_CYCLES        = 64;
    localparam int HOLD_AT_ITEM       = 40;
    localparam int RANDOM_PER_SEGMENT = 208;
    localparam int CYCLE_LIMIT        = 500000;
    localparam int LIGHT_IDLE_PCT     = 16;
    localparam int HEAVY_IDLE_PCT     = 72;

    typedef struct packed {
        logic               negative;
        logic [FIELD_W-1:0] field_number;
        logic [LINE_W-1:0]  line_number;
        logic [TIME_W-1:0]  time_tenths_ns;
        logic               out_of_range;
    } field_line_time_t;

    typedef struct packed {
        logic             is_525;
        logic [CNT_W-1:0] count;
        logic             known;
        field_line_time_t result;
    } directed_row_t;

    localparam field_line_time_t NO_RESULT  = '0;
    localparam field_line_time_t RES_ZERO   = '0;
    localparam field_line_time_t RES_LINE1  = '{1'b0, 3'd0, 9'd1, 20'd0, 1'b0};
    localparam field_line_time_t RES_FIELD1 = '{1'b0, 3'd1, 9'd0, 20'd0, 1'b0};
    localparam field_line_time_t RES_FIELD2 = '{1'b0, 3'd2, 9'd0, 20'd0, 1'b0};
    localparam field_line_time_t RES_FIELD4 = '{1'b0, 3'd4, 9'd0, 20'd0, 1'b0};
    localparam field_line_time_t RES_OOR    = '{1'b0, 3'd0, 9'd0, 20'd0, 1'b1};

    localparam int NUM_DIRECTED = 24;
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{MODE_625, 31'd0,          1'b1, RES_ZERO},
        '{MODE_625, 31'd1,          1'b0, NO_RESULT},
        '{MODE_625, 31'd442367,     1'b0, NO_RESULT},
        '{MODE_625, 31'd442368,     1'b1, RES_LINE1},
        '{MODE_625, 31'd138461183,  1'b0, NO_RESULT},
        '{MODE_625, 31'd138461184,  1'b1, RES_FIELD1},
        '{MODE_625, 31'd276480000,  1'b1, RES_FIELD2},
        '{MODE_625, 31'd552959999,  1'b0, NO_RESULT},
        '{MODE_625, 31'd552960000,  1'b1, RES_FIELD4},
        '{MODE_625, 31'd552960001,  1'b0, NO_RESULT},
        '{MODE_625, 31'd829440000,  1'b0, NO_RESULT},
        '{MODE_625, 31'd1105919999, 1'b0, NO_RESULT},
        '{MODE_625, 31'd1105920000, 1'b1, RES_OOR},
        '{MODE_625, 31'h7FFFFFFF,   1'b1, RES_OOR},
        '{MODE_525, 31'd0,          1'b1, RES_ZERO},
        '{MODE_525, 31'd439295,     1'b0, NO_RESULT},
        '{MODE_525, 31'd439296,     1'b1, RES_LINE1},
        '{MODE_525, 31'd115534848,  1'b1, RES_FIELD1},
        '{MODE_525, 31'd230630400,  1'b1, RES_FIELD2},
        '{MODE_525, 31'd230630401,  1'b0, NO_RESULT},
        '{MODE_525, 31'd461260799,  1'b0, NO_RESULT},
        '{MODE_525, 31'd461260800,  1'b1, RES_OOR},
        '{MODE_525, 31'd1105919999, 1'b1, RES_OOR},
        '{MODE_525, 31'h7FFFFFFF,   1'b1, RES_OOR}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    asfl_in_if  delay_if ();
    asfl_out_if result_if ();

    analog_samples_to_field_line_time dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .delay       (delay_if),
        .result      (result_if)
    );

    field_line_time_t expected_results [$];
    logic mode_525;
    int   tx_idle_pct;
    int   rx_idle_pct;
    bit   hold_pending;
    int   hold_left;
    int   error_count;
    int   cycle_count;

    always #5 clk = ~clk;

    function automatic field_line_time_t predict_field_line_time(input logic [CNT_W-1:0] count,
                                                                 input logic is_525);
        longint unsigned line_len, frame_len, half_len, first_lines, last_line, top_field;
        longint unsigned c, frame, line, sub, field;
        field_line_time_t r;
        line_len    = is_525 ? LINE_LEN_525 : LINE_LEN_625;
        frame_len   = is_525 ? FRAME_LEN_525 : FRAME_LEN_625;
        half_len    = is_525 ? HALF_LEN_525 : HALF_LEN_625;
        first_lines = is_525 ? 64'd263 : 64'd313;
        last_line   = is_525 ? 64'd524 : 64'd624;
        top_field   = is_525 ? 64'd3 : 64'd7;
        r = '0;
        c = count;
        if (c >= 2 * half_len)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        if (c >= half_len)
        begin
            // upper half: mirror line, sample and field back to a negative delay
            c     = c - 1;
            frame = c / frame_len;
            line  = (c % frame_len) / line_len;
            sub   = (c % frame_len) % line_len;
            field = 2 * frame;
            if (line >= first_lines)
            begin
                field = field + 1;
                line  = last_line - line;
            end
            else
            begin
                line = (first_lines - 1) - line;
            end
            sub   = line_len - 1 - sub;
            field = top_field - field;
            r.negative = (field != (top_field + 1) / 2);
        end
        else
        begin
            frame = c / frame_len;
            line  = (c % frame_len) / line_len;
            sub   = (c % frame_len) % line_len;
            field = 2 * frame;
            if (line >= first_lines)
            begin
                field = field + 1;
                line  = line - first_lines;
            end
        end
        r.field_number   = FIELD_W'(field);
        r.line_number    = LINE_W'(line);
        r.time_tenths_ns = TIME_W'((sub * 10000 + SUBS_PER_US / 2) / SUBS_PER_US);
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] pick_delay_count(input logic is_525);
        int unsigned seq_len, half_len, line_len, kind, n;
        seq_len  = is_525 ? 32'(2 * HALF_LEN_525) : 32'(2 * HALF_LEN_625);
        half_len = is_525 ? 32'(HALF_LEN_525) : 32'(HALF_LEN_625);
        line_len = is_525 ? 32'(LINE_LEN_525) : 32'(LINE_LEN_625);
        kind = $urandom_range(99, 0);
        if (kind < 65)
            return CNT_W'($urandom_range(seq_len - 1, 0));
        if (kind < 80)
        begin
            // line starts, one either side
            n = $urandom_range(seq_len / line_len, 0);
            return CNT_W'(n * line_len + $urandom_range(2, 0) - 1);
        end
        if (kind < 88)
            return CNT_W'(half_len + $urandom_range(4, 0) - 2);
        if (kind < 94)
            return CNT_W'($urandom_range(32'h7FFF_FFFF, seq_len));
        return CNT_W'($urandom());
    endfunction

    task automatic write_mode(input logic is_525);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= is_525;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        mode_525 = is_525;
    endtask

    task automatic wait_results_drained();
        delay_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_delay(input logic [CNT_W-1:0] count, input logic known,
                              input field_line_time_t known_result);
        while ($urandom_range(99, 0) < tx_idle_pct)
        begin
            delay_if.valid       <= 1'b0;
            delay_if.delay_count <= CNT_W'($urandom());
            @(posedge clk);
        end
        delay_if.valid       <= 1'b1;
        delay_if.delay_count <= count;
        @(posedge clk);
        while (!delay_if.ready)
            @(posedge clk);
        expected_results.push_back(known ? known_result
                                         : predict_field_line_time(count, mode_525));
    endtask

    // stimulus
    initial
    begin
        rst_n                <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_wr_data          <= 1'b0;
        delay_if.valid       <= 1'b0;
        delay_if.delay_count <= '0;
        mode_525     = MODE_625;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_pending = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (i == 0 || DIRECTED_ROWS[i].is_525 != mode_525)
            begin
                wait_results_drained();
                write_mode(DIRECTED_ROWS[i].is_525);
            end
            send_delay(DIRECTED_ROWS[i].count, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].result);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? LIGHT_IDLE_PCT : (phase == 1) ? HEAVY_IDLE_PCT : 0;
            rx_idle_pct = (phase == 0) ? HEAVY_IDLE_PCT : (phase == 1) ? LIGHT_IDLE_PCT : 0;
            for (int seg = 0; seg < 2; seg++)
            begin
                wait_results_drained();
                write_mode(logic'((phase % 2) ^ seg));
                for (int i = 0; i < RANDOM_PER_SEGMENT; i++)
                begin
                    // long receiver stall while words keep coming
                    if (seg == 0 && i == HOLD_AT_ITEM)
                        hold_pending = 1'b1;
                    send_delay(pick_delay_count(mode_525), 1'b0, NO_RESULT);
                end
            end
        end

        wait_results_drained();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // result side flow control
    initial
    begin
        result_if.ready <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        field_line_time_t got;
        field_line_time_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got = '{result_if.negative, result_if.field_number, result_if.line_number,
                    result_if.time_tenths_ns, result_if.out_of_range};
            if (expected_results.size() == 0)
            begin
                $error("result word with no delay word outstanding");
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.negative !== want.negative)
                begin
                    $error("negative: expected %0d, actual %0d", want.negative, got.negative);
                    error_count++;
                end
                if (got.field_number !== want.field_number)
                begin
                    $error("field_number: expected %0d, actual %0d",
                           want.field_number, got.field_number);
                    error_count++;
                end
                if (got.line_number !== want.line_number)
                begin
                    $error("line_number: expected %0d, actual %0d",
                           want.line_number, got.line_number);
                    error_count++;
                end
                if (got.time_tenths_ns !== want.time_tenths_ns)
                begin
                    $error("time_tenths_ns: expected %0d, actual %0d",
                           want.time_tenths_ns, got.time_tenths_ns);
                    error_count++;
                end
                if (got.out_of_range !== want.out_of_range)
                begin
                    $error("out_of_range: expected %0d, actual %0d",
                           want.out_of_range, got.out_of_range);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end
endmodule
